// ----- rtl/bftr_pkg.sv -----
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared types and constants of the bitmap font text renderer: request and
// job records, result record, register indexes and reset values.
// ----------------------------------------------------------------------------
package bftr_pkg;

  localparam int GLYPH_COUNT_DEF = 96;
  localparam int COLOR_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0]  CODE_BASE = 8'h20;
  localparam logic [7:0]  CODE_SPAN = 8'h60;

  localparam logic        KIND_LOAD = 1'b0;
  localparam logic        KIND_DRAW = 1'b1;

  localparam logic        CFG_IMG_W = 1'b0;
  localparam logic        CFG_IMG_H = 1'b1;

  localparam logic [11:0] IMG_W_RST = 12'd96;
  localparam logic [11:0] IMG_H_RST = 12'd64;

  typedef struct packed {
    logic        kind;
    logic        first_of_line;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  char_code;
    logic [6:0]  glyph_index;
    logic [7:0]  glyph_metrics;
    logic [31:0] glyph_bits;
    logic [15:0] color;
  } item_t;

  // one classified draw request for the scan engine
  typedef struct packed {
    logic        draw;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [2:0]  w;
    logic [2:0]  h;
    logic [31:0] mask;
    logic [15:0] adv;
  } job_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] color_out;
    logic [15:0] line_advance;
    logic        last;
  } res_t;

endpackage

// ----- rtl/bitmap_font_text_renderer_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_core
// Character generator: font load, glyph clipping and pixel write emission.
// ----------------------------------------------------------------------------
// path: a draw request is held in the front end while its glyph is read,
//   then passes the job queue, the scan engine and the result queue; the
//   closing result follows the last scanned pixel. The scan engine takes
//   a job, visits one glyph pixel per cycle (at most 49) while the result
//   queue has room and closes the character; a font load gives no result
// reset: pen, line advance and queues clear, image size returns to 96 x 64;
//   font contents are not cleared and must be loaded before use
module bitmap_font_text_renderer_core import bftr_pkg::*; #(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COLOR_BITS  = COLOR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // requests
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_kind,
  input  logic               in_first_of_line,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [7:0]         in_char_code,
  input  logic [6:0]         in_glyph_index,
  input  logic [7:0]         in_glyph_metrics,
  input  logic [31:0]        in_glyph_bits,
  input  logic [15:0]        in_color,
  // results
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_write_valid,
  output logic [11:0]        out_pixel_x,
  output logic [11:0]        out_pixel_y,
  output logic [15:0]        out_color_out,
  output logic signed [15:0] out_line_advance,
  output logic               out_last,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_wdata
);

  localparam int CLR_W = (COLOR_BITS < 16) ? COLOR_BITS : 16;
  localparam int JOB_W = $bits(job_t) + CLR_W;
  localparam int RES_W = $bits(res_t);

  item_t            in_item;
  logic [11:0]      img_w_r, img_h_r;

  logic             job_push, job_full, job_pop, job_empty;
  job_t             job_in, job_out;
  logic [CLR_W-1:0] color_in, color_out_q;
  logic [JOB_W-1:0] job_q;

  logic             res_push, res_full;
  res_t             res_in, res_out;
  logic [RES_W-1:0] res_q;

  always_comb begin
    in_item.kind          = in_kind;
    in_item.first_of_line = in_first_of_line;
    in_item.origin_x      = in_origin_x;
    in_item.origin_y      = in_origin_y;
    in_item.char_code     = in_char_code;
    in_item.glyph_index   = in_glyph_index;
    in_item.glyph_metrics = in_glyph_metrics;
    in_item.glyph_bits    = in_glyph_bits;
    in_item.color         = in_color;
  end

  // image size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMG_W: img_w_r <= cfg_wdata;
        CFG_IMG_H: img_h_r <= cfg_wdata;
        default:   img_w_r <= img_w_r;
      endcase
    end
  end

  bftr_front #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COLOR_BITS  (COLOR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .job_push  (job_push),
    .job       (job_in),
    .job_color (color_in),
    .job_full  (job_full)
  );

  bftr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({job_in, color_in}),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_q),
    .empty (job_empty)
  );

  assign job_out     = job_q[JOB_W-1:CLR_W];
  assign color_out_q = job_q[CLR_W-1:0];

  bftr_back #(
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_out),
    .job_color (color_out_q),
    .job_pop   (job_pop),
    .img_w     (img_w_r),
    .img_h     (img_h_r),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  bftr_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_q),
    .empty (out_empty)
  );

  assign res_out          = res_q;
  assign out_write_valid  = res_out.write_valid;
  assign out_pixel_x      = res_out.pixel_x;
  assign out_pixel_y      = res_out.pixel_y;
  assign out_color_out    = res_out.color_out;
  assign out_line_advance = res_out.line_advance;
  assign out_last         = res_out.last;

endmodule

// ----- rtl/bftr_fifo.sv -----
// ----------------------------------------------------------------------------
// bftr_fifo
// Small register queue used between the front end, the scan engine and the
// result port.
// ----------------------------------------------------------------------------
module bftr_fifo import bftr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/bftr_front.sv -----
// ----------------------------------------------------------------------------
// bftr_front
// Front end: takes requests, writes font entries, reads the glyph of a draw
// request, keeps the pen and line advance and hands a job to the scan engine.
// ----------------------------------------------------------------------------
module bftr_front import bftr_pkg::*; #(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COLOR_BITS  = COLOR_BITS_DEF,
  localparam int CLR_W      = (COLOR_BITS < 16) ? COLOR_BITS : 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  item_t            in_item,
  output logic             job_push,
  output job_t             job,
  output logic [CLR_W-1:0] job_color,
  input  logic             job_full
);

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [39:0]      font_mem [GLYPH_COUNT];
  logic [39:0]      rd_data_r;

  logic             state_r, state_nxt;
  logic [15:0]      pen_x_r, pen_x_nxt;
  logic [15:0]      pen_y_r, pen_y_nxt;
  logic [15:0]      adv_r, adv_nxt;

  logic             fol_r;
  logic [15:0]      org_x_r, org_y_r;
  logic             code_ok_r;
  logic [CLR_W-1:0] color_r;

  logic             accept, is_draw, load_ok, code_ok;
  logic [7:0]       code_off;
  logic [8:0]       wr_ext, rd_ext;
  logic [2:0]       w, h;
  logic [1:0]       yoff;
  logic             drawn;
  logic [15:0]      eff_x, eff_y, eff_adv, step;

  assign in_full  = (state_r == ST_READ) || job_full;
  assign accept   = in_push && !in_full;
  assign is_draw  = (in_item.kind == KIND_DRAW);

  assign wr_ext   = {2'b00, in_item.glyph_index};
  assign load_ok  = accept && !is_draw && (wr_ext < 9'(GLYPH_COUNT));

  assign code_off = in_item.char_code - CODE_BASE;
  assign rd_ext   = {1'b0, code_off};
  assign code_ok  = (code_off < CODE_SPAN) && (rd_ext < 9'(GLYPH_COUNT));

  always_ff @(posedge clk) begin
    if (load_ok) begin
      font_mem[wr_ext[IDX_W-1:0]] <= {in_item.glyph_metrics, in_item.glyph_bits};
    end
    if (accept && is_draw && code_ok) begin
      rd_data_r <= font_mem[rd_ext[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_draw) begin
      fol_r     <= in_item.first_of_line;
      org_x_r   <= in_item.origin_x;
      org_y_r   <= in_item.origin_y;
      code_ok_r <= code_ok;
      color_r   <= in_item.color[CLR_W-1:0];
    end
  end

  // glyph metrics and effective pen once the font entry is out
  assign w       = rd_data_r[39:37];
  assign h       = rd_data_r[36:34];
  assign yoff    = rd_data_r[33:32];
  assign drawn   = code_ok_r && (w != 3'd0);
  assign eff_x   = fol_r ? org_x_r : pen_x_r;
  assign eff_y   = fol_r ? org_y_r : pen_y_r;
  assign eff_adv = fol_r ? 16'd0 : adv_r;
  assign step    = {13'd0, w} + 16'd1;

  always_comb begin
    job.draw = drawn;
    job.x0   = eff_x;
    job.y0   = eff_y + {14'd0, yoff};
    job.w    = w;
    job.h    = h;
    job.mask = rd_data_r[31:0];
    job.adv  = drawn ? eff_adv + step : eff_adv;
  end
  assign job_color = color_r;
  assign job_push  = (state_r == ST_READ) && !job_full;

  always_comb begin
    state_nxt = state_r;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    adv_nxt   = adv_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_draw) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (job_push) begin
          state_nxt = ST_IDLE;
          pen_x_nxt = drawn ? eff_x + step : eff_x;
          pen_y_nxt = eff_y;
          adv_nxt   = job.adv;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pen_x_r <= '0;
      pen_y_r <= '0;
      adv_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      adv_r   <= adv_nxt;
    end
  end

  a_push_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (state_r == ST_READ))
    else $error("job pushed outside read state");

  a_hold_while_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> in_full)
    else $error("request taken while a glyph read is pending");

  a_draw_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_draw) |=> (state_r == ST_READ))
    else $error("draw request did not enter read state");

endmodule

// ----- rtl/bftr_back.sv -----
// ----------------------------------------------------------------------------
// bftr_back
// Scan engine: walks a glyph one pixel a cycle while the result queue is not
// full, clips it to the image, emits pixel writes, then the closing result.
// ----------------------------------------------------------------------------
module bftr_back import bftr_pkg::*; #(
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  localparam int CLR_W     = (COLOR_BITS < 16) ? COLOR_BITS : 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_empty,
  input  job_t             job,
  input  logic [CLR_W-1:0] job_color,
  output logic             job_pop,
  input  logic [11:0]      img_w,
  input  logic [11:0]      img_h,
  output logic             res_push,
  output res_t             res,
  input  logic             res_full
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       col_r, col_nxt;
  logic [2:0]       row_r, row_nxt;
  logic [31:0]      mask_r, mask_nxt;
  logic [15:0]      x0_r, y0_r, adv_r;
  logic [2:0]       w_r, h_r;
  logic [CLR_W-1:0] color_r;

  logic [16:0]      xs, ys;
  logic             vis, step;

  assign xs   = {x0_r[15], x0_r} + {14'd0, col_r};
  assign ys   = {y0_r[15], y0_r} + {14'd0, row_r};
  // mask shifts left each pixel, so positions past 31 read as clear
  assign vis  = !xs[16] && (xs < {5'd0, img_w}) && !ys[16] && (ys < {5'd0, img_h})
                && mask_r[31];
  assign step = (state_r == ST_SCAN) && !res_full;

  assign job_pop  = (state_r == ST_IDLE) && !job_empty;
  assign res_push = (step && vis) || ((state_r == ST_FINAL) && !res_full);

  always_comb begin
    if (state_r == ST_FINAL) begin
      res.write_valid  = 1'b0;
      res.pixel_x      = '0;
      res.pixel_y      = '0;
      res.color_out    = '0;
      res.line_advance = adv_r;
      res.last         = 1'b1;
    end else begin
      res.write_valid  = 1'b1;
      res.pixel_x      = xs[11:0];
      res.pixel_y      = ys[11:0];
      res.color_out    = 16'(color_r);
      res.line_advance = '0;
      res.last         = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      ST_IDLE: begin
        if (job_pop) begin
          col_nxt   = '0;
          row_nxt   = '0;
          mask_nxt  = job.mask;
          state_nxt = (job.draw && (job.h != 3'd0)) ? ST_SCAN : ST_FINAL;
        end
      end
      ST_SCAN: begin
        if (step) begin
          mask_nxt = {mask_r[30:0], 1'b0};
          if (col_r == w_r - 3'd1) begin
            col_nxt = '0;
            row_nxt = row_r + 3'd1;
            if (row_r == h_r - 3'd1) begin
              state_nxt = ST_FINAL;
            end
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end
      ST_FINAL: begin
        if (!res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    mask_r <= mask_nxt;
    if (job_pop) begin
      x0_r    <= job.x0;
      y0_r    <= job.y0;
      w_r     <= job.w;
      h_r     <= job.h;
      adv_r   <= job.adv;
      color_r <= job_color;
    end
  end

  a_last_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.last) |-> (state_r == ST_FINAL))
    else $error("closing result outside final state");

  a_write_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.write_valid) |-> ((res.pixel_x < img_w) && (res.pixel_y < img_h)))
    else $error("pixel write outside the image");

  a_row_in_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((row_r < h_r) && (col_r < w_r)))
    else $error("scan position outside the glyph");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap font text renderer. Font loads and
// character draws go in through the request queue with random gaps. Each
// draw's pixel writes and its closing advance record are predicted and
// compared field by field as they are popped. Image size is changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import bftr_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;

  logic               in_push = 1'b0;
  logic               in_full;
  logic               in_kind = KIND_LOAD;
  logic               in_first_of_line = 1'b0;
  logic [15:0]        in_origin_x = '0;
  logic [15:0]        in_origin_y = '0;
  logic [7:0]         in_char_code = '0;
  logic [6:0]         in_glyph_index = '0;
  logic [7:0]         in_glyph_metrics = '0;
  logic [31:0]        in_glyph_bits = '0;
  logic [15:0]        in_color = '0;

  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_write_valid;
  logic [11:0]        out_pixel_x;
  logic [11:0]        out_pixel_y;
  logic [15:0]        out_color_out;
  logic signed [15:0] out_line_advance;
  logic               out_last;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_IMG_W;
  logic [11:0]        cfg_wdata = '0;

  bitmap_font_text_renderer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_first_of_line (in_first_of_line),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_char_code     (in_char_code),
    .in_glyph_index   (in_glyph_index),
    .in_glyph_metrics (in_glyph_metrics),
    .in_glyph_bits    (in_glyph_bits),
    .in_color         (in_color),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_write_valid  (out_write_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_color_out    (out_color_out),
    .out_line_advance (out_line_advance),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---- prediction state
  logic [7:0]  glyph_meta_m [GLYPH_COUNT_DEF];
  logic [31:0] glyph_mask_m [GLYPH_COUNT_DEF];
  logic [15:0] pen_x_m = '0;
  logic [15:0] pen_y_m = '0;
  logic [15:0] line_adv_m = '0;
  logic [11:0] img_w_m = IMG_W_RST;
  logic [11:0] img_h_m = IMG_H_RST;

  item_t       req_q [$];
  res_t        write_exp_q [$];
  int          font_used [$];
  item_t       held_req;
  int          idle_left = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  int          err_count = 0;

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // updates the font or renders one character into expected pixel writes and its closing record
  task automatic render_request(input item_t r);
    logic [7:0]  p;
    logic [2:0]  w;
    logic [2:0]  h;
    logic [1:0]  yo;
    logic [31:0] mk;
    logic [15:0] ysum;
    int          x0, y0, x, y, pos;
    res_t        e;
    if (r.kind == KIND_LOAD) begin
      if (r.glyph_index < GLYPH_COUNT_DEF) begin
        glyph_meta_m[r.glyph_index] = r.glyph_metrics;
        glyph_mask_m[r.glyph_index] = r.glyph_bits;
      end
      return;
    end
    if (r.first_of_line) begin
      pen_x_m    = r.origin_x;
      pen_y_m    = r.origin_y;
      line_adv_m = '0;
    end
    p = r.char_code - CODE_BASE;
    if (p < CODE_SPAN && p < GLYPH_COUNT_DEF) begin
      w  = glyph_meta_m[p][7:5];
      h  = glyph_meta_m[p][4:2];
      yo = glyph_meta_m[p][1:0];
      mk = glyph_mask_m[p];
      if (w != 0) begin
        ysum = pen_y_m + 16'(yo);
        x0 = int'($signed(pen_x_m));
        y0 = int'($signed(ysum));
        for (int rr = 0; rr < h; rr++) begin
          y = y0 + rr;
          if (y < 0 || y >= int'(img_h_m)) continue;
          for (int cc = 0; cc < w; cc++) begin
            x = x0 + cc;
            pos = rr * w + cc;
            if (x < 0 || x >= int'(img_w_m)) continue;
            // mask positions past bit 0 count as clear
            if (pos >= 32) continue;
            if (mk[31 - pos]) begin
              e = '0;
              e.write_valid = 1'b1;
              e.pixel_x = 12'(x);
              e.pixel_y = 12'(y);
              e.color_out = r.color;
              write_exp_q.push_back(e);
            end
          end
        end
        pen_x_m    = pen_x_m + 16'(w) + 16'd1;
        line_adv_m = line_adv_m + 16'(w) + 16'd1;
      end
    end
    e = '0;
    e.line_advance = line_adv_m;
    e.last = 1'b1;
    write_exp_q.push_back(e);
  endtask

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (write_exp_q.size() == 0) begin
      note_mismatch($sformatf("result with no request pending: wv=%0b x=%0d y=%0d last=%0b",
                              got.write_valid, got.pixel_x, got.pixel_y, got.last));
      return;
    end
    want = write_exp_q.pop_front();
    if (got.write_valid !== want.write_valid)
      note_mismatch($sformatf("write_valid %0b, want %0b", got.write_valid, want.write_valid));
    if (got.pixel_x !== want.pixel_x)
      note_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
    if (got.pixel_y !== want.pixel_y)
      note_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
    if (got.color_out !== want.color_out)
      note_mismatch($sformatf("color_out %h, want %h", got.color_out, want.color_out));
    if (got.line_advance !== want.line_advance)
      note_mismatch($sformatf("line_advance %h, want %h", got.line_advance, want.line_advance));
    if (got.last !== want.last)
      note_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
  endtask

  // ---- request driver
  always @(posedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_push   <= 1'b0;
      idle_left <= 0;
    end else if (!(in_push && in_full)) begin
      if (in_push) render_request(held_req);
      if (idle_left != 0) begin
        in_push   <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        held_req         <= nxt;
        in_kind          <= nxt.kind;
        in_first_of_line <= nxt.first_of_line;
        in_origin_x      <= nxt.origin_x;
        in_origin_y      <= nxt.origin_y;
        in_char_code     <= nxt.char_code;
        in_glyph_index   <= nxt.glyph_index;
        in_glyph_metrics <= nxt.glyph_metrics;
        in_glyph_bits    <= nxt.glyph_bits;
        in_color         <= nxt.color;
        in_push          <= 1'b1;
        idle_left        <= pick_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // ---- result monitor
  always @(posedge clk) begin
    res_t got_r;
    int   g;
    if (!rst_n) begin
      out_pop    <= 1'b0;
      stall_left <= 0;
    end else begin
      g = 0;
      if (out_pop && !out_empty) begin
        got_r = '{out_write_valid, out_pixel_x, out_pixel_y, out_color_out,
                  out_line_advance, out_last};
        check_result(got_r);
        g = pick_gap();
      end
      if (stall_left != 0) begin
        out_pop    <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (g != 0) begin
        out_pop    <= 1'b0;
        stall_left <= g - 1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // ---- stimulus
  function automatic item_t mk_load(input logic [6:0] idx, input logic [7:0] met,
                                    input logic [31:0] bits);
    item_t r;
    r.kind          = KIND_LOAD;
    r.first_of_line = 1'($urandom_range(0, 1));
    r.origin_x      = 16'($urandom);
    r.origin_y      = 16'($urandom);
    r.char_code     = 8'($urandom);
    r.glyph_index   = idx;
    r.glyph_metrics = met;
    r.glyph_bits    = bits;
    r.color         = 16'($urandom);
    return r;
  endfunction

  function automatic item_t mk_draw(input logic fol, input logic [15:0] ox,
                                    input logic [15:0] oy, input logic [7:0] code,
                                    input logic [15:0] col);
    item_t r;
    r.kind          = KIND_DRAW;
    r.first_of_line = fol;
    r.origin_x      = ox;
    r.origin_y      = oy;
    r.char_code     = code;
    r.glyph_index   = 7'($urandom);
    r.glyph_metrics = 8'($urandom);
    r.glyph_bits    = $urandom;
    r.color         = col;
    return r;
  endfunction

  function automatic logic [31:0] rand_mask();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 32'hFFFF_FFFF;
    if (roll < 15) return 32'h0;
    return $urandom;
  endfunction

  // mostly near the image so that clipping on each edge gets hit
  function automatic logic [15:0] pick_origin(input int lim);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'(int'($urandom_range(0, lim + 16)) - 8);
    if (roll < 90) return 16'($urandom);
    if (roll < 95) return 16'h7FF8 + 16'($urandom_range(0, 7));
    return 16'h8000 + 16'($urandom_range(0, 7));
  endfunction

  task automatic queue_phase(input int n, input int w, input int h);
    int          got, roll, idx;
    bit          placed;
    logic        fol;
    logic [7:0]  code;
    got = 0;
    placed = 1'b0;
    while (got < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 25 || font_used.size() == 0) begin
        idx = $urandom_range(0, 127);
        req_q.push_back(mk_load(7'(idx), 8'($urandom), rand_mask()));
        // loads past the font end are ignored by the block
        if (idx < GLYPH_COUNT_DEF) begin
          font_used.push_back(idx);
          got++;
        end
      end else begin
        fol = !placed || ($urandom_range(0, 99) < 15);
        if ($urandom_range(0, 99) < 8)
          code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
        else
          code = 8'(font_used[$urandom_range(0, font_used.size() - 1)]) + CODE_BASE;
        req_q.push_back(mk_draw(fol, pick_origin(w), pick_origin(h), code, 16'($urandom)));
        placed = 1'b1;
        got++;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMG_W) img_w_m = val;
    else img_h_m = val;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (req_q.size() != 0 || in_push || write_exp_q.size() != 0);
    // a trailing font load gives no result but may still be in flight
    repeat (80) @(posedge clk);
  endtask

  initial begin
    int ph_w [6];
    int ph_h [6];
    ph_w = '{1, 4095, 0, 4095, 1, 96};
    ph_h = '{1, 4095, 0, 1, 4095, 64};
    ph_w[2] = $urandom_range(8, 40);
    ph_h[2] = $urandom_range(4, 20);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset image size of 96 x 64
    req_q.push_back(mk_load(7'd0, 8'hFF, 32'hFFFF_FFFF));   // 7x7, mask runs out
    req_q.push_back(mk_load(7'd95, 8'h6C, 32'hA5A5_A5A5));  // 3x3 at the font end
    req_q.push_back(mk_load(7'd1, 8'h1F, 32'hFFFF_FFFF));   // zero width
    req_q.push_back(mk_load(7'd2, 8'h24, 32'h8000_0000));   // single pixel
    req_q.push_back(mk_load(7'd127, 8'hFF, 32'hFFFF_FFFF)); // ignored
    req_q.push_back(mk_load(7'd96, 8'hFF, 32'hFFFF_FFFF));  // ignored
    font_used = '{0, 95, 1, 2};
    req_q.push_back(mk_draw(1'b1, 16'd0, 16'd0, 8'h20, 16'hFFFF));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h7F, 16'h0000));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h21, 16'h1234));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h1F, 16'h5555));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h80, 16'hAAAA));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'hFF, 16'h0F0F));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h00, 16'hF0F0));
    req_q.push_back(mk_draw(1'b1, 16'hFFFD, 16'hFFFE, 8'h20, 16'h00FF));
    req_q.push_back(mk_draw(1'b1, 16'd92, 16'd60, 8'h20, 16'hFF00));
    // baseline plus offset wraps negative, pen x wraps after the advance
    req_q.push_back(mk_draw(1'b1, 16'h7FFF, 16'h7FFE, 8'h20, 16'h8001));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h22, 16'h7FFE));
    req_q.push_back(mk_draw(1'b1, 16'h8000, 16'h8000, 8'h7F, 16'hC3C3));
    req_q.push_back(mk_load(7'd0, 8'h00, 32'h0000_0000));
    req_q.push_back(mk_draw(1'b1, 16'd10, 16'd10, 8'h20, 16'h3C3C));
    req_q.push_back(mk_draw(1'b1, 16'd95, 16'd63, 8'h22, 16'h9999));
    req_q.push_back(mk_draw(1'b0, 16'd0, 16'd0, 8'h22, 16'h6666));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_IMG_W, 12'(ph_w[ph]));
      write_reg(CFG_IMG_H, 12'(ph_h[ph]));
      no_idle = (ph == 2);
      queue_phase(40, ph_w[ph], ph_h[ph]);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bftr_pkg.sv
rtl/bftr_fifo.sv
rtl/bftr_front.sv
rtl/bftr_back.sv
rtl/bitmap_font_text_renderer_core.sv
verif/tb_top.sv
